// ----- hw/rtl/ffha_pkg.sv -----
// Shared constants, codes and controller/datapath types for the first-fit heap allocator.
`default_nettype none
package ffha_pkg;

  localparam int ARENA_MAX   = 256;
  localparam int ARENA_MIN   = 16;
  localparam int HDR_BYTES   = 5;
  localparam int ALIGN_BYTES = 4;
  localparam int HDR_W       = 9;
  localparam int ADDR_W      = 8;

  localparam logic [1:0] MODE_ALLOC   = 2'd0;
  localparam logic [1:0] MODE_FREE    = 2'd1;
  localparam logic [1:0] MODE_REALLOC = 2'd2;

  localparam logic [1:0] ST_DONE   = 2'd0;
  localparam logic [1:0] ST_NOFIT  = 2'd1;
  localparam logic [1:0] ST_NOADDR = 2'd2;

  typedef enum logic [3:0] {
    S_INIT, S_IDLE, S_DISPATCH, S_A_RD, S_A_CHK, S_A_WR1, S_A_WR2, S_G_START,
    S_F_RD, S_F_CHK, S_F_EVAL, S_N_RD, S_N_CHK, S_FR_WR, S_S_WR1, S_DONE
  } state_t;

  typedef enum logic [4:0] {
    DP_NOP, DP_CFG, DP_INIT_WR, DP_LOAD, DP_WALK_START, DP_READ_CUR, DP_ADVANCE,
    DP_TAKE_TGT, DP_READ_NEXT, DP_TAKE_NEXT, DP_FREE_WR, DP_ALLOC_WR1, DP_ALLOC_WR2,
    DP_SHRINK_WR1, DP_SHRINK_WR2, DP_FAIL_NOFIT, DP_FAIL_ADDR, DP_SET_RES, DP_EMIT
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } cmd_t;

  typedef struct packed {
    logic       end_walk;
    logic       d_fit;
    logic       d_hit;
    logic       tfree;
    logic       grow;
    logic       split_alloc;
    logic       split_shrink;
    logic [1:0] mode;
    logic       out_free;
  } sts_t;

endpackage
`default_nettype wire

// ----- hw/rtl/ffha_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module ffha_ram #(
  parameter int WIDTH = 9,
  parameter int DEPTH = 256
) (
  input  wire                     clk,
  input  wire                     we,
  input  wire [$clog2(DEPTH)-1:0] waddr,
  input  wire [WIDTH-1:0]         wdata,
  input  wire [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]        rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ----- hw/rtl/ffha_datapath.sv -----
// Datapath: walk pointers, captured headers, header RAM, merge arithmetic and result register.
`default_nettype none
module ffha_datapath import ffha_pkg::*; (
  input  wire         clk,
  input  wire         rst,
  input  cmd_t        cmd,
  output sts_t        sts,
  input  wire  [8:0]  cfg_data,
  input  wire  [1:0]  s_tuser,
  input  wire  [15:0] s_tdata,
  output logic        m_tvalid,
  input  wire         m_tready,
  output logic [15:0] m_tdata
);
  localparam logic [8:0] H9   = 9'(HDR_BYTES);
  localparam logic [7:0] H8   = 8'(HDR_BYTES);
  localparam logic [9:0] AMSK = 10'(ALIGN_BYTES - 1);

  logic [8:0]        arena;
  logic [1:0]        mode;
  logic [7:0]        adj;
  logic [7:0]        addr;
  logic [8:0]        cur;
  logic [7:0]        prv, psz, tgt, tsz, nsz, res;
  logic              pfree, hp, tfree, nfree;
  logic [1:0]        st;
  logic [HDR_W-1:0]  rdata, wdata;
  logic [7:0]        waddr, raddr;
  logic              we;

  logic [9:0] need;
  logic [7:0] adj_calc;
  logic [8:0] diff, nxt, step;
  logic [7:0] d_size, r_off, r_size, cfg_sat;
  logic       d_free;

  assign d_size = rdata[7:0];
  assign d_free = rdata[8];

  always_comb begin
    need     = 10'(s_tdata[7:0]) + 10'(HDR_BYTES) + AMSK;
    need     = need & ~AMSK;
    adj_calc = 8'(need - 10'(HDR_BYTES));
    diff     = {1'b0, tsz} - {1'b0, adj};
    nxt      = 9'(tgt) + H9 + 9'(tsz);
    step     = cur + H9 + 9'(d_size);
    r_off    = tgt + H8 + adj;
    r_size   = tsz - adj - H8;
    if (cfg_data < 9'(ARENA_MIN)) cfg_sat = 8'(ARENA_MIN - HDR_BYTES);
    else if (cfg_data > 9'(ARENA_MAX)) cfg_sat = 8'(ARENA_MAX - HDR_BYTES);
    else cfg_sat = 8'(cfg_data - H9);
  end

  always_comb begin
    sts.end_walk     = cur >= arena;
    sts.d_fit        = d_free && (d_size >= adj);
    sts.d_hit        = (cur + 9'd1) == {1'b0, addr};
    sts.tfree        = tfree;
    sts.grow         = diff[8];
    sts.split_alloc  = !diff[8] && (diff[7:0] >= H8);
    sts.split_shrink = !diff[8] && (diff[7:0] > 8'(2 * HDR_BYTES));
    sts.mode         = mode;
    sts.out_free     = !m_tvalid || m_tready;
  end

  always_comb begin
    we    = 1'b0;
    waddr = tgt;
    wdata = {1'b0, tsz};
    raddr = cur[7:0];
    case (cmd.op)
      DP_INIT_WR: begin
        we    = 1'b1;
        waddr = '0;
        wdata = {1'b1, 8'(arena - H9)};
      end
      DP_READ_NEXT: raddr = nxt[7:0];
      DP_FREE_WR: begin
        we = 1'b1;
        if (hp && pfree && nfree) begin
          waddr = prv;
          wdata = {1'b1, psz + 8'(2 * HDR_BYTES) + tsz + nsz};
        end else if (hp && pfree) begin
          waddr = prv;
          wdata = {1'b1, psz + H8 + tsz};
        end else if (nfree) begin
          wdata = {1'b1, tsz + H8 + nsz};
        end else begin
          wdata = {1'b1, tsz};
        end
      end
      DP_ALLOC_WR1: begin
        we    = 1'b1;
        wdata = {1'b0, sts.split_alloc ? adj : tsz};
      end
      DP_ALLOC_WR2: begin
        we    = 1'b1;
        waddr = r_off;
        wdata = {1'b1, r_size};
      end
      DP_SHRINK_WR1: begin
        we    = 1'b1;
        wdata = {1'b0, adj};
      end
      DP_SHRINK_WR2: begin
        we    = 1'b1;
        waddr = r_off;
        wdata = {1'b1, nfree ? r_size + H8 + nsz : r_size};
      end
      default: ;
    endcase
  end

  ffha_ram #(.WIDTH(HDR_W), .DEPTH(ARENA_MAX)) u_hdr (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      arena <= 9'(ARENA_MAX);
    end else if (cmd.op == DP_CFG) begin
      arena <= 9'(cfg_sat) + H9;
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      DP_LOAD: begin
        mode <= s_tuser;
        adj  <= adj_calc;
        addr <= s_tdata[15:8];
        res  <= '0;
        st   <= ST_DONE;
      end
      DP_WALK_START: begin
        cur <= '0;
        hp  <= 1'b0;
      end
      DP_ADVANCE: begin
        prv   <= cur[7:0];
        psz   <= d_size;
        pfree <= d_free;
        hp    <= 1'b1;
        cur   <= step;
      end
      DP_TAKE_TGT: begin
        tgt   <= cur[7:0];
        tsz   <= d_size;
        tfree <= d_free;
      end
      DP_TAKE_NEXT: begin
        nfree <= (nxt < arena) && d_free;
        nsz   <= d_size;
      end
      DP_ALLOC_WR1, DP_SHRINK_WR1, DP_SET_RES: res <= tgt + 8'd1;
      DP_FAIL_NOFIT: begin
        res <= '0;
        st  <= ST_NOFIT;
      end
      DP_FAIL_ADDR: begin
        res <= '0;
        st  <= ST_NOADDR;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.op == DP_EMIT) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == DP_EMIT) begin
      m_tdata <= {6'd0, st, res};
    end
  end
endmodule
`default_nettype wire

// ----- hw/rtl/ffha_ctrl.sv -----
// Controller: sequences header walks, splits and merges through datapath commands.
`default_nettype none
module ffha_ctrl import ffha_pkg::*; (
  input  wire  clk,
  input  wire  rst,
  input  sts_t sts,
  output cmd_t cmd,
  input  wire  s_tvalid,
  output logic s_tready,
  input  wire  cfg_valid,
  output logic cfg_ready
);
  state_t state, state_next;
  logic   second, second_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_INIT;
      second <= 1'b0;
    end else begin
      state  <= state_next;
      second <= second_next;
    end
  end

  always_comb begin
    state_next  = state;
    second_next = second;
    cmd.op      = DP_NOP;
    s_tready    = 1'b0;
    cfg_ready   = 1'b0;
    case (state)
      S_INIT: begin
        cmd.op     = DP_INIT_WR;
        state_next = S_IDLE;
      end
      S_IDLE: begin
        cfg_ready = 1'b1;
        if (cfg_valid) begin
          cmd.op     = DP_CFG;
          state_next = S_INIT;
        end else begin
          s_tready = 1'b1;
          if (s_tvalid) begin
            cmd.op      = DP_LOAD;
            second_next = 1'b0;
            state_next  = S_DISPATCH;
          end
        end
      end
      S_DISPATCH: begin
        cmd.op = DP_WALK_START;
        if (sts.mode == MODE_ALLOC) state_next = S_A_RD;
        else if (sts.mode == MODE_FREE || sts.mode == MODE_REALLOC) state_next = S_F_RD;
        else state_next = S_DONE;
      end
      S_A_RD: begin
        if (sts.end_walk) begin
          cmd.op     = DP_FAIL_NOFIT;
          state_next = S_DONE;
        end else begin
          cmd.op     = DP_READ_CUR;
          state_next = S_A_CHK;
        end
      end
      S_A_CHK: begin
        if (sts.d_fit) begin
          cmd.op     = DP_TAKE_TGT;
          state_next = S_A_WR1;
        end else begin
          cmd.op     = DP_ADVANCE;
          state_next = S_A_RD;
        end
      end
      S_A_WR1: begin
        cmd.op = DP_ALLOC_WR1;
        if (sts.split_alloc) state_next = S_A_WR2;
        else if (sts.mode == MODE_REALLOC) state_next = S_G_START;
        else state_next = S_DONE;
      end
      S_A_WR2: begin
        cmd.op     = DP_ALLOC_WR2;
        state_next = (sts.mode == MODE_REALLOC) ? S_G_START : S_DONE;
      end
      S_G_START: begin
        cmd.op      = DP_WALK_START;
        second_next = 1'b1;
        state_next  = S_F_RD;
      end
      S_F_RD: begin
        if (sts.end_walk) begin
          cmd.op     = DP_FAIL_ADDR;
          state_next = S_DONE;
        end else begin
          cmd.op     = DP_READ_CUR;
          state_next = S_F_CHK;
        end
      end
      S_F_CHK: begin
        if (sts.d_hit) begin
          cmd.op     = DP_TAKE_TGT;
          state_next = S_F_EVAL;
        end else begin
          cmd.op     = DP_ADVANCE;
          state_next = S_F_RD;
        end
      end
      S_F_EVAL: begin
        if (second) begin
          state_next = S_N_RD;
        end else if (sts.tfree) begin
          cmd.op     = DP_FAIL_ADDR;
          state_next = S_DONE;
        end else if (sts.mode == MODE_FREE) begin
          state_next = S_N_RD;
        end else if (sts.grow) begin
          cmd.op     = DP_WALK_START;
          state_next = S_A_RD;
        end else if (sts.split_shrink) begin
          state_next = S_S_WR1;
        end else begin
          cmd.op     = DP_SET_RES;
          state_next = S_DONE;
        end
      end
      S_S_WR1: begin
        cmd.op     = DP_SHRINK_WR1;
        state_next = S_N_RD;
      end
      S_N_RD: begin
        cmd.op     = DP_READ_NEXT;
        state_next = S_N_CHK;
      end
      S_N_CHK: begin
        cmd.op     = DP_TAKE_NEXT;
        state_next = S_FR_WR;
      end
      S_FR_WR: begin
        cmd.op     = (sts.mode == MODE_REALLOC && !second) ? DP_SHRINK_WR2 : DP_FREE_WR;
        state_next = S_DONE;
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.op     = DP_EMIT;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_INIT;
    endcase
  end
endmodule
`default_nettype wire

// ----- hw/rtl/first_fit_heap_allocator_unit.sv -----
// Top level of the first-fit heap allocator: controller, datapath and assertions.
//
// Manages an arena of up to 256 bytes as an implicit list of blocks with 5-byte
// headers kept in a 256-entry header RAM. One request at a time: an allocate or
// an address lookup reads one header at a time (one RAM read port, registered
// read), walking the headers from offset 0; a growing reallocate walks three
// times (lookup, first-fit search, second lookup).
// The result is held in an output register, so the next request is taken while it
// waits. A configuration beat, taken only between requests, resets the arena to one
// free block; after reset the block writes that free block and is then ready.
`default_nettype none
module first_fit_heap_allocator_unit import ffha_pkg::*; (
  input  wire         clk,
  input  wire         rst,
  input  wire         s_tvalid,
  output logic        s_tready,
  input  wire  [15:0] s_tdata,   // [7:0] request_bytes, [15:8] block_address
  input  wire  [1:0]  s_tuser,   // [1:0] mode
  output logic        m_tvalid,
  input  wire         m_tready,
  output logic [15:0] m_tdata,   // [7:0] result_address, [9:8] status, zero above
  input  wire         cfg_valid,
  output logic        cfg_ready,
  input  wire  [8:0]  cfg_data   // arena_bytes
);
  cmd_t cmd;
  sts_t sts;

  ffha_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .sts      (sts),
    .cmd      (cmd),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready)
  );

  ffha_datapath u_dp (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .sts     (sts),
    .cfg_data(cfg_data),
    .s_tuser (s_tuser),
    .s_tdata (s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata)
  );

  a_no_double_take: assert property (@(posedge clk) disable iff (rst)
    !(s_tvalid && s_tready && cfg_valid && cfg_ready))
    else $error("request and configuration taken together");

  a_busy_after_take: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready && !cfg_ready)
    else $error("new beat taken while a request is in progress");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[9:8] == ST_DONE || m_tdata[9:8] == ST_NOFIT ||
                  m_tdata[9:8] == ST_NOADDR))
    else $error("bad status code");

  a_fail_no_addr: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[9:8] != ST_DONE) |-> m_tdata[7:0] == 8'd0)
    else $error("failed request returned an address");
endmodule
`default_nettype wire

// ----- sim/tb_top.sv -----
// Self-checking testbench for the first-fit heap allocator: directed and random requests.
`default_nettype none
class heap_scoreboard;
  logic [8:0] hdr [ffha_pkg::ARENA_MAX];
  int unsigned span;
  int unsigned nblk;
  logic [7:0] want_addr [$];
  logic [1:0] want_st [$];
  int errors;
  int checked;
  int granted, nofit, noaddr;

  function void set_arena(logic [8:0] v);
    int unsigned a;
    a = v;
    if (a < 16) a = 16;
    if (a > 256) a = 256;
    span = a;
    foreach (hdr[i]) hdr[i] = '0;
    hdr[0] = {1'b1, 8'(a - 5)};
    nblk = 1;
  endfunction

  function int unsigned sz(int unsigned o);
    return o < 256 ? int'(hdr[o][7:0]) : 0;
  endfunction

  function bit isfree(int unsigned o);
    return o < 256 ? hdr[o][8] : 1'b0;
  endfunction

  function void put(int unsigned o, bit f, int unsigned s);
    if (o < 256) hdr[o] = {f, 8'(s)};
  endfunction

  function int unsigned rounded(int unsigned r);
    int unsigned need;
    need = r + 5;
    if (need % 4 != 0) need += 4 - need % 4;
    return need - 5;
  endfunction

  function bit place(int unsigned req, output int unsigned addr);
    int unsigned adj, o, s;
    adj = rounded(req);
    o = 0;
    addr = 0;
    while (o < span) begin
      s = sz(o);
      if (isfree(o) && s >= adj) begin
        if (s - adj >= 5) begin
          put(o, 0, adj);
          put(o + 5 + adj, 1, s - adj - 5);
          nblk++;
        end else begin
          put(o, 0, s);
        end
        addr = o + 1;
        return 1;
      end
      o += 5 + s;
    end
    return 0;
  endfunction

  function bit lookup(int unsigned addr, output int unsigned at, output int unsigned prv,
                      output bit hp);
    int unsigned o;
    o = 0;
    hp = 0;
    prv = 0;
    at = 0;
    while (o < span) begin
      if (o + 1 == addr) begin
        at = o;
        return 1;
      end
      prv = o;
      hp = 1;
      o += 5 + sz(o);
    end
    return 0;
  endfunction

  function void release_blk(int unsigned o, int unsigned prv, bit hp);
    int unsigned s, n;
    bit nf, pf;
    s = sz(o);
    n = o + 5 + s;
    nf = n < span && isfree(n);
    pf = hp && isfree(prv);
    put(o, 1, s);
    if (pf && nf) put(prv, 1, sz(prv) + 10 + s + sz(n));
    else if (pf) put(prv, 1, sz(prv) + 5 + s);
    else if (nf) put(o, 1, s + 5 + sz(n));
  endfunction

  function void note_request(logic [1:0] mode, logic [7:0] req, logic [7:0] addr);
    int unsigned res, o, prv, s, adj, r, rs, n;
    logic [1:0] st;
    bit hp;
    res = 0;
    st = ffha_pkg::ST_DONE;
    if (mode == ffha_pkg::MODE_ALLOC) begin
      if (!place(req, res)) st = ffha_pkg::ST_NOFIT;
    end else if (mode == ffha_pkg::MODE_FREE) begin
      if (lookup(addr, o, prv, hp) && !isfree(o)) release_blk(o, prv, hp);
      else st = ffha_pkg::ST_NOADDR;
    end else if (mode == ffha_pkg::MODE_REALLOC) begin
      if (!lookup(addr, o, prv, hp) || isfree(o)) begin
        st = ffha_pkg::ST_NOADDR;
      end else begin
        s = sz(o);
        adj = rounded(req);
        if (s < adj) begin
          if (!place(req, res)) begin
            res = 0;
            st = ffha_pkg::ST_NOFIT;
          end else if (lookup(addr, o, prv, hp)) begin
            release_blk(o, prv, hp);
          end
        end else begin
          if (s - adj > 10) begin
            r = o + 5 + adj;
            rs = s - adj - 5;
            n = r + 5 + rs;
            put(o, 0, adj);
            put(r, 1, rs);
            if (n < span && isfree(n)) put(r, 1, rs + 5 + sz(n));
          end
          res = o + 1;
        end
      end
    end
    if (st == ffha_pkg::ST_NOFIT) nofit++;
    else if (st == ffha_pkg::ST_NOADDR) noaddr++;
    else if (res != 0) granted++;
    want_addr.push_back(8'(res));
    want_st.push_back(st);
  endfunction

  function void check_result(logic [15:0] d);
    logic [7:0] ea;
    logic [1:0] es;
    if (want_addr.size() == 0) begin
      $error("unexpected result beat %h", d);
      errors++;
      return;
    end
    ea = want_addr.pop_front();
    es = want_st.pop_front();
    checked++;
    if (d[7:0] !== ea) begin
      $error("result_address expected %0d actual %0d", ea, d[7:0]);
      errors++;
    end
    if (d[9:8] !== es) begin
      $error("status expected %0d actual %0d", es, d[9:8]);
      errors++;
    end
    if (d[15:10] !== 6'd0) begin
      $error("pad expected 0 actual %h", d[15:10]);
      errors++;
    end
  endfunction
endclass

module tb_top;
  import ffha_pkg::*;

  logic clk = 0;
  logic rst = 1;
  logic s_tvalid = 0;
  logic s_tready;
  logic [15:0] s_tdata = '0;
  logic [1:0] s_tuser = '0;
  logic m_tvalid;
  logic m_tready = 0;
  logic [15:0] m_tdata;
  logic cfg_valid = 0;
  logic cfg_ready;
  logic [8:0] cfg_data = '0;
  bit calm = 0;
  int n_req = 0;
  logic [7:0] live [$];
  heap_scoreboard sb = new();

  always #5 clk = ~clk;

  first_fit_heap_allocator_unit DUT (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      sb.check_result(m_tdata);
      if (m_tdata[9:8] == ST_DONE && m_tdata[7:0] != 0) live.push_back(m_tdata[7:0]);
    end
  end

  initial begin
    int k;
    forever begin
      @(posedge clk);
      if (calm || $urandom_range(0, 3) != 0) begin
        m_tready <= 1;
      end else begin
        m_tready <= 0;
        k = $urandom_range(1, 9);
        repeat (k - 1) @(posedge clk);
      end
    end
  end

  task automatic send(logic [1:0] mode, logic [7:0] req, logic [7:0] addr);
    if (!calm && $urandom_range(0, 4) == 0) repeat ($urandom_range(1, 9)) @(posedge clk);
    s_tvalid <= 1;
    s_tuser <= mode;
    s_tdata <= {addr, req};
    do @(posedge clk); while (!s_tready);
    sb.note_request(mode, req, addr);
    n_req++;
    s_tvalid <= 0;
    @(posedge clk);
  endtask

  task automatic drain();
    int guard;
    guard = 0;
    while (sb.want_addr.size() != 0 && guard < 100000) begin
      @(posedge clk);
      guard++;
    end
    repeat (20) @(posedge clk);
  endtask

  task automatic set_arena(logic [8:0] v);
    cfg_valid <= 1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 0;
    sb.set_arena(v);
    live.delete();
  endtask

  function automatic logic [7:0] pick_addr();
    int i;
    if (live.size() == 0 || $urandom_range(0, 9) == 0) return 8'($urandom_range(0, 255));
    i = $urandom_range(0, live.size() - 1);
    return live[i];
  endfunction

  task automatic random_phase(int count);
    int m;
    logic [7:0] req;
    repeat (count) begin
      m = $urandom_range(0, 19);
      req = ($urandom_range(0, 5) == 0) ? 8'($urandom_range(0, 255))
                                         : 8'($urandom_range(0, 40));
      if (m < 8) send(MODE_ALLOC, req, 8'($urandom));
      else if (m < 14) send(MODE_FREE, 8'($urandom), pick_addr());
      else if (m < 19) send(MODE_REALLOC, req, pick_addr());
      else send(2'd3, 8'($urandom), 8'($urandom));
    end
  endtask

  initial begin
    sb.set_arena(9'd256);
    repeat (4) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    send(MODE_ALLOC, 8'd0, 8'd0);
    send(MODE_ALLOC, 8'd3, 8'd0);
    send(MODE_ALLOC, 8'd255, 8'd0);
    send(MODE_ALLOC, 8'd20, 8'd0);
    send(MODE_ALLOC, 8'd40, 8'd0);
    send(MODE_FREE, 8'd0, 8'd9);
    send(MODE_FREE, 8'd0, 8'd9);
    send(MODE_FREE, 8'd0, 8'd0);
    send(MODE_FREE, 8'hFF, 8'hFF);
    send(MODE_REALLOC, 8'd0, 8'd1);
    send(MODE_REALLOC, 8'd100, 8'd1);
    send(MODE_REALLOC, 8'd255, 8'd1);
    send(MODE_REALLOC, 8'd0, 8'd2);
    send(MODE_FREE, 8'd0, 8'd1);
    send(MODE_ALLOC, 8'd150, 8'd0);
    send(MODE_ALLOC, 8'd150, 8'd0);
    send(2'd3, 8'hFF, 8'hFF);
    send(2'd3, 8'h00, 8'h00);
    drain();
    foreach (live[i]) send(MODE_FREE, 8'hAA, live[i]);
    drain();
    random_phase(400);
    drain();
    set_arena(9'd16);
    random_phase(150);
    drain();
    set_arena(9'd0);
    random_phase(100);
    drain();
    set_arena(9'h1FF);
    random_phase(300);
    drain();
    set_arena(9'd100);
    random_phase(300);
    drain();
    set_arena(9'd256);
    random_phase(350);
    calm = 1;
    random_phase(300);
    drain();
    $display("Ran %0d requests over six arena sizes: %0d grants, %0d no-fit, %0d bad address",
             n_req, sb.granted, sb.nofit, sb.noaddr);
    if (sb.errors == 0 && sb.want_addr.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #20000000;
    $display("Timeout");
    $display("Testbench completed WITH ERRORS");
    $finish;
  end
endmodule
`default_nettype wire

// ----- files.f -----
hw/rtl/ffha_pkg.sv
hw/rtl/ffha_ram.sv
hw/rtl/ffha_datapath.sv
hw/rtl/ffha_ctrl.sv
hw/rtl/first_fit_heap_allocator_unit.sv
sim/tb_top.sv
